// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the canonical Huffman table decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define ASSERT_IMPLIES(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`else

`define ASSERT_IMPLIES(name, pre, post, msg)
`define ASSERT_NEXT(name, pre, post, msg)

`endif

`endif

// ===== hdl/chtd_pkg.sv =====
// Shared constants, types and control structs of the canonical Huffman table decoder.
`timescale 1ns / 1ps
`default_nettype none

package chtd_pkg;

  localparam int DEF_MAX_SYMBOLS   = 512;
  localparam int DEF_MAX_CODE_BITS = 15;

  localparam int ALPHA_W   = 10;
  localparam int OP_W      = 2;
  localparam int LEN_W     = 4;
  localparam int WIN_W     = 16;
  localparam int SYM_W     = 9;
  localparam int LIM_W     = 32;
  localparam int TBL_DEPTH = 16;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 10'd20;
  localparam logic [WIN_W-1:0]   WIN_MASK    = 16'hFFFE;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_BUILD  = 2'd1,
    OP_DECODE = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_SWEEP_TAIL,
    ST_LIMITS,
    ST_FILL,
    ST_FILL_TAIL,
    ST_DEC_FIND,
    ST_DEC_DIST,
    ST_DEC_READ,
    ST_DEC_OUT
  } state_t;

  typedef struct packed {
    logic count_clr;
    logic count_en;
    logic lim_step;
    logic fill_start;
    logic fill_en;
    logic dec_find;
    logic dec_dist;
  } lim_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/chtd_if.sv =====
// Valid/ready channel interfaces for the input items and the result items.
`timescale 1ns / 1ps
`default_nettype none

interface chtd_in_if;
  import chtd_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [LEN_W-1:0] code_length;
  logic [WIN_W-1:0] bit_window;

  modport source (output valid, output op, output code_length, output bit_window,
                  input ready);
  modport sink   (input valid, input op, input code_length, input bit_window,
                  output ready);
endinterface

interface chtd_out_if;
  import chtd_pkg::*;

  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic [LEN_W-1:0] code_bits;

  modport source (output valid, output symbol, output code_bits, input ready);
  modport sink   (input valid, input symbol, input code_bits, output ready);
endinterface

`default_nettype wire

// ===== hdl/chtd_len_mem.sv =====
// Code length memory with its load pointer and fill mark.
`timescale 1ns / 1ps
`default_nettype none

module chtd_len_mem #(
  parameter int MAX_SYMBOLS = chtd_pkg::DEF_MAX_SYMBOLS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             load_en,
  input  logic [chtd_pkg::LEN_W-1:0]       load_len,
  input  logic                             idx_clr,
  input  logic                             rd_en,
  input  logic [$clog2(MAX_SYMBOLS)-1:0]   rd_addr,
  output logic [chtd_pkg::LEN_W-1:0]       rd_len
);
  import chtd_pkg::*;

  localparam int AW = $clog2(MAX_SYMBOLS);
  localparam int CW = $clog2(MAX_SYMBOLS + 1);

  logic [LEN_W-1:0] mem [MAX_SYMBOLS];
  logic [CW-1:0]    load_idx_r, load_idx_nxt;
  logic [CW-1:0]    fill_r, fill_nxt;
  logic [LEN_W-1:0] rd_data_r;
  logic             rd_hit_r;
  logic             wr_en;

  // Loads past the end of the store are dropped.
  assign wr_en = load_en && (load_idx_r < CW'(MAX_SYMBOLS));

  // Loads always run upward from entry zero, so the written entries since
  // reset form a prefix; entries at or above the fill mark read as zero.
  always_comb begin
    load_idx_nxt = load_idx_r;
    fill_nxt     = fill_r;
    if (idx_clr) begin
      load_idx_nxt = '0;
    end else if (wr_en) begin
      load_idx_nxt = load_idx_r + 1'b1;
      if (load_idx_r >= fill_r) begin
        fill_nxt = load_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_idx_r <= '0;
      fill_r     <= '0;
    end else begin
      load_idx_r <= load_idx_nxt;
      fill_r     <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[load_idx_r[AW-1:0]] <= load_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_hit_r  <= CW'(rd_addr) < fill_r;
    end
  end

  assign rd_len = rd_hit_r ? rd_data_r : '0;

endmodule

`default_nettype wire

// ===== hdl/chtd_sym_mem.sv =====
// Symbol table memory, one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module chtd_sym_mem #(
  parameter int MAX_SYMBOLS = chtd_pkg::DEF_MAX_SYMBOLS
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(MAX_SYMBOLS)-1:0] wr_addr,
  input  logic [chtd_pkg::SYM_W-1:0]     wr_data,
  input  logic                           rd_en,
  input  logic [$clog2(MAX_SYMBOLS)-1:0] rd_addr,
  output logic [chtd_pkg::SYM_W-1:0]     rd_data
);
  import chtd_pkg::*;

  logic [SYM_W-1:0] mem [MAX_SYMBOLS];
  logic [SYM_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== hdl/chtd_limits.sv =====
// Per-length counts, upper limits, first slots, fill pointers and the decode datapath.
`timescale 1ns / 1ps
`default_nettype none

module chtd_limits #(
  parameter int MAX_SYMBOLS   = chtd_pkg::DEF_MAX_SYMBOLS,
  parameter int MAX_CODE_BITS = chtd_pkg::DEF_MAX_CODE_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  chtd_pkg::lim_ctrl_t              ctrl,
  input  logic [chtd_pkg::LEN_W-1:0]       len,
  input  logic [chtd_pkg::WIN_W-1:0]       win,
  input  logic [$clog2(MAX_SYMBOLS+1)-1:0] size,
  output logic                             lim_last,
  output logic                             fill_wr,
  output logic [$clog2(MAX_SYMBOLS)-1:0]   fill_addr,
  output logic [chtd_pkg::LEN_W-1:0]       code_bits,
  output logic [$clog2(MAX_SYMBOLS)-1:0]   dec_addr
);
  import chtd_pkg::*;

  localparam int AW   = $clog2(MAX_SYMBOLS);
  localparam int CW   = $clog2(MAX_SYMBOLS + 1);
  localparam int SH_W = $clog2(WIN_W + 1);
  localparam logic [LEN_W-1:0] TOP_LEN = LEN_W'(MAX_CODE_BITS);

  logic [CW-1:0]    count_r [TBL_DEPTH];
  logic [CW-1:0]    next_r  [TBL_DEPTH];
  logic [CW-1:0]    fs_r    [TBL_DEPTH];
  logic [LIM_W-1:0] ul_r    [TBL_DEPTH];
  logic [LIM_W-1:0] acc_r;
  logic [LEN_W-1:0] idx_r;
  logic [LEN_W-1:0] bits_r;
  logic [LIM_W-1:0] dist_r;

  logic             len_ok;
  logic [LEN_W-1:0] prev_idx;
  logic [LIM_W-1:0] acc_sum;
  logic [SH_W-1:0]  step_sh;
  logic [LIM_W-1:0] ul_new;
  logic [CW-1:0]    fs_new;
  logic [LEN_W-1:0] bits_c;
  logic [LEN_W-1:0] prev_bits;
  logic [SH_W-1:0]  dist_sh;
  logic [LIM_W-1:0] diff;
  logic [LIM_W-1:0] slot;

  // Zero lengths and lengths beyond the longest code count as absent.
  assign len_ok = (len != '0) && (len <= TOP_LEN);

  always_ff @(posedge clk) begin
    for (int k = 0; k < TBL_DEPTH; k++) begin
      if (ctrl.count_clr) begin
        count_r[k] <= '0;
      end else if (ctrl.count_en && len_ok && (len == LEN_W'(k))) begin
        count_r[k] <= count_r[k] + 1'b1;
      end
    end
  end

  // One code length per step: limit and first slot of length idx_r.
  assign prev_idx = idx_r - LEN_W'(1);
  assign acc_sum  = acc_r + LIM_W'(count_r[idx_r]);
  assign step_sh  = SH_W'(WIN_W) - SH_W'(idx_r);
  assign ul_new   = acc_sum << step_sh;
  assign fs_new   = fs_r[prev_idx] + count_r[prev_idx];
  assign lim_last = (idx_r == TOP_LEN);

  always_ff @(posedge clk) begin
    if (ctrl.count_clr) begin
      acc_r <= '0;
      idx_r <= LEN_W'(1);
    end else if (ctrl.lim_step) begin
      acc_r <= acc_sum << 1;
      idx_r <= idx_r + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TBL_DEPTH; k++) begin
        ul_r[k] <= '0;
        fs_r[k] <= '0;
      end
    end else if (ctrl.lim_step) begin
      ul_r[idx_r] <= ul_new;
      fs_r[idx_r] <= fs_new;
    end
  end

  // Canonical fill: each length hands out consecutive slots from its first slot.
  assign fill_addr = next_r[len][AW-1:0];
  assign fill_wr   = ctrl.fill_en && len_ok && (next_r[len] < CW'(MAX_SYMBOLS));

  always_ff @(posedge clk) begin
    for (int k = 0; k < TBL_DEPTH; k++) begin
      if (ctrl.fill_start) begin
        next_r[k] <= fs_r[k];
      end else if (ctrl.fill_en && len_ok && (len == LEN_W'(k))) begin
        next_r[k] <= next_r[k] + 1'b1;
      end
    end
  end

  // The shortest length whose limit lies above the window wins.
  always_comb begin
    bits_c = TOP_LEN;
    for (int k = MAX_CODE_BITS - 1; k >= 1; k--) begin
      if (LIM_W'(win) < ul_r[k]) begin
        bits_c = LEN_W'(k);
      end
    end
  end

  assign prev_bits = bits_r - LEN_W'(1);
  assign dist_sh   = SH_W'(WIN_W) - SH_W'(bits_r);
  assign diff      = LIM_W'(win) - ul_r[prev_bits];

  always_ff @(posedge clk) begin
    if (ctrl.dec_find) begin
      bits_r <= bits_c;
    end
    if (ctrl.dec_dist) begin
      dist_r <= diff >> dist_sh;
    end
  end

  assign slot      = LIM_W'(fs_r[bits_r]) + dist_r;
  assign dec_addr  = (slot < LIM_W'(size)) ? slot[AW-1:0] : '0;
  assign code_bits = bits_r;

endmodule

`default_nettype wire

// ===== hdl/canonical_huffman_table_decoder.sv =====
// Top level of the canonical Huffman table decoder: sequencer, registers and result stage.
//
//   channel   direction  handshake           payload
//   in_ch     in         valid / ready       op, code_length, bit_window
//   out_ch    out        valid / ready       symbol, code_bits
//   cfg_*     in         cfg_wr_en (no wait) cfg_wr_data = alphabet_size
//
// Loads may follow each other in every cycle. A decode item holds the block through
// limit compare, distance, slot and symbol memory read, then the result register;
// a full result register stretches this. A build item holds it through the symbol
// memory clear sweep, the per-length limit steps and the fill walk.
// Reset is synchronous and runs no clearing pass; until the first build decodes
// return symbol zero.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module canonical_huffman_table_decoder #(
  parameter int MAX_SYMBOLS   = chtd_pkg::DEF_MAX_SYMBOLS,
  parameter int MAX_CODE_BITS = chtd_pkg::DEF_MAX_CODE_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  chtd_in_if.sink                      in_ch,
  chtd_out_if.source                   out_ch,
  input  logic                         cfg_wr_en,
  input  logic [chtd_pkg::ALPHA_W-1:0] cfg_wr_data
);
  import chtd_pkg::*;

  localparam int AW = $clog2(MAX_SYMBOLS);
  localparam int CW = $clog2(MAX_SYMBOLS + 1);
  localparam logic [LEN_W-1:0] TOP_LEN = LEN_W'(MAX_CODE_BITS);

  state_t           state_r, state_nxt;
  logic [ALPHA_W-1:0] alpha_r;
  logic [CW-1:0]    size_r;
  logic [CW-1:0]    size_c;
  logic [WIN_W-1:0] win_r;
  logic [AW-1:0]    j_r, j_nxt;
  logic             rd_vld_r;
  logic [AW-1:0]    rd_idx_r;
  logic             table_ok_r;
  logic             out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0] out_sym_r;
  logic [LEN_W-1:0] out_bits_r;

  logic             in_acc;
  logic             out_free;
  logic             out_load;
  logic             sweep_last;
  logic             fill_last;
  logic             j_in_size;

  lim_ctrl_t        ctrl;
  logic             lim_last;
  logic             fill_wr;
  logic [AW-1:0]    fill_addr;
  logic [LEN_W-1:0] lim_code_bits;
  logic [AW-1:0]    dec_addr;

  logic             len_load;
  logic             len_rd_en;
  logic [LEN_W-1:0] len_rd;
  logic             sym_wr_en;
  logic [AW-1:0]    sym_wr_addr;
  logic [SYM_W-1:0] sym_wr_data;
  logic             sym_rd_en;
  logic [SYM_W-1:0] sym_rd_data;

  assign in_ch.ready    = (state_r == ST_IDLE);
  assign in_acc         = in_ch.valid && in_ch.ready;
  assign out_free       = !out_valid_r || out_ch.ready;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.symbol  = out_sym_r;
  assign out_ch.code_bits = out_bits_r;

  // The build works on at most MAX_SYMBOLS entries; the same figure bounds decode slots.
  assign size_c = (int'(alpha_r) >= MAX_SYMBOLS) ? CW'(MAX_SYMBOLS) : CW'(alpha_r);

  assign j_in_size  = CW'(j_r) < size_r;
  assign sweep_last = (j_r == AW'(MAX_SYMBOLS - 1));
  assign fill_last  = (({1'b0, CW'(j_r)} + 1'b1) >= {1'b0, size_r});
  assign len_load   = in_acc && (in_ch.op == OP_LOAD);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (op_t'(in_ch.op))
            OP_LOAD:   state_nxt = ST_IDLE;
            OP_BUILD:  state_nxt = ST_SWEEP;
            OP_DECODE: state_nxt = ST_DEC_FIND;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SWEEP: begin
        if (sweep_last) begin
          state_nxt = ST_SWEEP_TAIL;
        end
      end
      ST_SWEEP_TAIL: state_nxt = ST_LIMITS;
      ST_LIMITS: begin
        if (lim_last) begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        if (fill_last) begin
          state_nxt = ST_FILL_TAIL;
        end
      end
      ST_FILL_TAIL: state_nxt = ST_IDLE;
      ST_DEC_FIND:  state_nxt = ST_DEC_DIST;
      ST_DEC_DIST:  state_nxt = ST_DEC_READ;
      ST_DEC_READ:  state_nxt = ST_DEC_OUT;
      ST_DEC_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer. The sweep clears every symbol slot while it reads
  // the lengths for counting; the fill walk rereads them and places the symbols.
  always_comb begin
    ctrl        = '0;
    len_rd_en   = 1'b0;
    sym_wr_en   = 1'b0;
    sym_wr_addr = j_r;
    sym_wr_data = '0;
    sym_rd_en   = 1'b0;
    out_load    = 1'b0;
    j_nxt       = '0;
    unique case (state_r)
      ST_IDLE: begin
        ctrl.count_clr = in_acc && (in_ch.op == OP_BUILD);
      end
      ST_SWEEP: begin
        len_rd_en     = j_in_size;
        sym_wr_en     = 1'b1;
        ctrl.count_en = rd_vld_r;
        j_nxt         = sweep_last ? '0 : j_r + 1'b1;
      end
      ST_SWEEP_TAIL: begin
        ctrl.count_en = rd_vld_r;
      end
      ST_LIMITS: begin
        ctrl.lim_step = 1'b1;
      end
      ST_FILL: begin
        ctrl.fill_start = (j_r == '0);
        ctrl.fill_en    = rd_vld_r;
        len_rd_en       = j_in_size;
        sym_wr_en       = fill_wr;
        sym_wr_addr     = fill_addr;
        sym_wr_data     = SYM_W'(rd_idx_r);
        j_nxt           = fill_last ? '0 : j_r + 1'b1;
      end
      ST_FILL_TAIL: begin
        ctrl.fill_en = rd_vld_r;
        sym_wr_en    = fill_wr;
        sym_wr_addr  = fill_addr;
        sym_wr_data  = SYM_W'(rd_idx_r);
      end
      ST_DEC_FIND: ctrl.dec_find = 1'b1;
      ST_DEC_DIST: ctrl.dec_dist = 1'b1;
      ST_DEC_READ: sym_rd_en = 1'b1;
      ST_DEC_OUT:  out_load = out_free;
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      alpha_r     <= ALPHA_RESET;
      size_r      <= '0;
      j_r         <= '0;
      rd_vld_r    <= 1'b0;
      table_ok_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      j_r         <= j_nxt;
      rd_vld_r    <= len_rd_en;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        alpha_r <= cfg_wr_data;
      end
      if (ctrl.count_clr) begin
        size_r <= size_c;
      end
      // Once a sweep has cleared the whole symbol memory every entry is defined.
      if ((state_r == ST_SWEEP) && sweep_last) begin
        table_ok_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (len_rd_en) begin
      rd_idx_r <= j_r;
    end
    if (in_acc && (in_ch.op == OP_DECODE)) begin
      win_r <= in_ch.bit_window & WIN_MASK;
    end
    if (out_load) begin
      out_sym_r  <= table_ok_r ? sym_rd_data : '0;
      out_bits_r <= lim_code_bits;
    end
  end

  chtd_len_mem #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_len_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .load_en  (len_load),
    .load_len (in_ch.code_length),
    .idx_clr  (ctrl.count_clr),
    .rd_en    (len_rd_en),
    .rd_addr  (j_r),
    .rd_len   (len_rd)
  );

  chtd_limits #(
    .MAX_SYMBOLS   (MAX_SYMBOLS),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_limits (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .len       (len_rd),
    .win       (win_r),
    .size      (size_r),
    .lim_last  (lim_last),
    .fill_wr   (fill_wr),
    .fill_addr (fill_addr),
    .code_bits (lim_code_bits),
    .dec_addr  (dec_addr)
  );

  chtd_sym_mem #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_sym_mem (
    .clk     (clk),
    .wr_en   (sym_wr_en),
    .wr_addr (sym_wr_addr),
    .wr_data (sym_wr_data),
    .rd_en   (sym_rd_en),
    .rd_addr (dec_addr),
    .rd_data (sym_rd_data)
  );

  // The symbol memory is never written while a decode is in flight.
  `ASSERT_IMPLIES(a_no_write_in_decode, (state_r == ST_DEC_FIND) || (state_r == ST_DEC_DIST) || (state_r == ST_DEC_READ) || (state_r == ST_DEC_OUT), !sym_wr_en, "symbol memory written during decode")

  // A finished decode with a free result register shows its result next cycle.
  `ASSERT_NEXT(a_result_loaded, (state_r == ST_DEC_OUT) && !out_valid_r, out_valid_r, "decode result not loaded")

  // A finished decode waits while the previous result is still held.
  `ASSERT_NEXT(a_result_waits, (state_r == ST_DEC_OUT) && out_valid_r && !out_ch.ready, state_r == ST_DEC_OUT, "decode result dropped under stall")

  // The matched code length is always a real length.
  `ASSERT_IMPLIES(a_bits_range, state_r == ST_DEC_OUT, (lim_code_bits != '0) && (lim_code_bits <= TOP_LEN), "code length out of range")

  // The length memory is only read by the two build walks.
  `ASSERT_IMPLIES(a_len_reads, len_rd_en, (state_r == ST_SWEEP) || (state_r == ST_FILL), "length read outside build")

endmodule

`default_nettype wire
